// File: src/fcg_pkg.sv
// Shared types, constants and helper functions for the FAT32 format geometry block.
package fcg_pkg;

	localparam int FCG_DIV_BITS  = 20;
	localparam int FCG_LATENCY   = FCG_DIV_BITS + 4;
	localparam int FCG_TABLE_LEN = 6;

	localparam logic [31:0] FCG_BOUND [FCG_TABLE_LEN] = '{
		32'd66600, 32'd532480, 32'd16777216, 32'd33554432, 32'd67108864, 32'hFFFF_FFFF
	};
	// log2 of the cluster size for each size class; the first class is too small
	localparam logic [2:0] FCG_SHIFT [FCG_TABLE_LEN] = '{
		3'd0, 3'd0, 3'd3, 3'd4, 3'd5, 3'd6
	};
	localparam logic [2:0] FCG_SHIFT_MAX = 3'd6;
	localparam logic [6:0] FCG_RSVD_SMALL = 7'd32;
	localparam logic [6:0] FCG_RSVD_LARGE = 7'd64;

	typedef struct packed {
		logic        too_small;
		logic [2:0]  sh;
		logic [31:0] total;
		logic [13:0] dvs;
		logic [32:0] rem;
		logic [19:0] quot;
	} fcg_item_t;

	// (31 + spc) rounded down to a multiple of spc, for spc = 1, 8, 16, 32, 64
	function automatic logic [6:0] fcg_rsvd(input logic [2:0] sh);
		logic [6:0] r;
		r = (sh == FCG_SHIFT_MAX) ? FCG_RSVD_LARGE : FCG_RSVD_SMALL;
		return r;
	endfunction

	// (256 * spc + 2) / 2 = 128 * spc + 1
	function automatic logic [13:0] fcg_divisor(input logic [2:0] sh);
		logic [13:0] d;
		d = (14'd1 << (4'(sh) + 4'd7)) + 14'd1;
		return d;
	endfunction

endpackage

// File: src/fat32_format_geometry.sv
// Top level of the FAT32 format geometry pipeline.
// Each item passes through the front stages, the divider stages and the back stages in order.
// Throughput: one item per cycle; busy is never raised, so start may stay high.
// Depth is set by the restoring divider for the FAT size, one quotient bit per stage.
// Reset (arst_n low, asynchronous) drops every item in flight; no result follows.
// The receiver cannot stall: each result shows for one cycle with done high.
module fat32_format_geometry import fcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] total_sectors,
	output logic        done,
	output logic        too_small,
	output logic [6:0]  sectors_per_cluster,
	output logic [6:0]  reserved_sectors,
	output logic [19:0] fat_size_sectors,
	output logic [21:0] data_start_sector,
	output logic [26:0] free_clusters
);

	// front: size class, divisor, rounded-up dividend
	logic      front_vld;
	fcg_item_t front_item;
	// divider: FAT size quotient
	logic      div_vld;
	fcg_item_t div_item;

	// every stage advances each cycle, so an item is always taken
	assign busy = 1'b0;

	fcg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.total_sectors (total_sectors),
		.vld           (front_vld),
		.item          (front_item)
	);

	fcg_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (front_vld),
		.in_item  (front_item),
		.out_vld  (div_vld),
		.out_item (div_item)
	);

	// back: data start, free clusters, zeroing of too-small results
	fcg_back u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_vld              (div_vld),
		.in_item             (div_item),
		.done                (done),
		.too_small           (too_small),
		.sectors_per_cluster (sectors_per_cluster),
		.reserved_sectors    (reserved_sectors),
		.fat_size_sectors    (fat_size_sectors),
		.data_start_sector   (data_start_sector),
		.free_clusters       (free_clusters)
	);

	// a result only ever follows an accepted item by the fixed latency
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, FCG_LATENCY))
		else $error("result without a matching item");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##FCG_LATENCY done)
		else $error("accepted item lost in the pipeline");

	a_layout_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !too_small) |-> (sectors_per_cluster != 7'd0 &&
		data_start_sector == 22'(reserved_sectors) + {1'b0, fat_size_sectors, 1'b0}))
		else $error("data start does not match reserved area plus two FATs");

	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && too_small) |-> (sectors_per_cluster == 7'd0 && reserved_sectors == 7'd0 &&
		fat_size_sectors == 20'd0 && data_start_sector == 22'd0 && free_clusters == 27'd0))
		else $error("too-small result carries nonzero fields");

endmodule

// File: src/fcg_front.sv
// Front stages: size class lookup, then divisor and rounded dividend setup.
module fcg_front import fcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] total_sectors,
	output logic        vld,
	output fcg_item_t   item
);

	logic        vld_s1, vld_s2;
	logic [31:0] total_s1;
	logic        small_s1;
	logic [2:0]  sh_s1;
	fcg_item_t   item_s2;

	logic        small_c;
	logic [2:0]  sh_c;
	fcg_item_t   nxt_c;
	logic [6:0]  rsvd_c;

	// pick the first class whose bound holds the total
	always_comb begin
		sh_c    = FCG_SHIFT_MAX;
		small_c = 1'b0;
		for (int i = FCG_TABLE_LEN - 1; i >= 0; i--) begin
			if (total_sectors <= FCG_BOUND[i]) begin
				sh_c    = FCG_SHIFT[i];
				small_c = (i == 0);
			end
		end
	end

	// dividend = total - rsvd + divisor - 1, never below total; zero for a too-small total
	always_comb begin
		rsvd_c          = fcg_rsvd(sh_s1);
		nxt_c.too_small = small_s1;
		nxt_c.sh        = sh_s1;
		nxt_c.total     = total_s1;
		nxt_c.dvs       = fcg_divisor(sh_s1);
		nxt_c.quot      = '0;
		nxt_c.rem       = {1'b0, total_s1} + 33'(nxt_c.dvs - 14'd1 - 14'(rsvd_c));
		if (small_s1) begin
			nxt_c.rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		total_s1 <= total_sectors;
		small_s1 <= small_c;
		sh_s1    <= sh_c;
		item_s2  <= nxt_c;
	end

	assign vld  = vld_s2;
	assign item = item_s2;

endmodule

// File: src/fcg_divider.sv
// Restoring divider, one quotient bit per pipeline stage.
module fcg_divider import fcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_vld,
	input  fcg_item_t in_item,
	output logic      out_vld,
	output fcg_item_t out_item
);

	fcg_item_t item_sn [FCG_DIV_BITS];
	logic      vld_sn  [FCG_DIV_BITS];
	fcg_item_t chain   [FCG_DIV_BITS + 1];
	logic      chain_v [FCG_DIV_BITS + 1];

	assign chain[0]   = in_item;
	assign chain_v[0] = in_vld;

	for (genvar g = 0; g < FCG_DIV_BITS; g++) begin : g_step
		localparam int BIT = FCG_DIV_BITS - 1 - g;
		fcg_item_t   nxt;
		logic [32:0] shd;
		logic [33:0] diff;

		// subtract divisor << BIT when it fits, setting that quotient bit
		always_comb begin
			shd  = 33'(chain[g].dvs) << BIT;
			diff = {1'b0, chain[g].rem} - {1'b0, shd};
			nxt  = chain[g];
			if (!diff[33]) begin
				nxt.rem       = diff[32:0];
				nxt.quot[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[g] <= 1'b0;
			end else begin
				vld_sn[g] <= chain_v[g];
			end
		end

		always_ff @(posedge clk) begin
			item_sn[g] <= nxt;
		end

		assign chain[g + 1]   = item_sn[g];
		assign chain_v[g + 1] = vld_sn[g];
	end

	assign out_vld  = chain_v[FCG_DIV_BITS];
	assign out_item = chain[FCG_DIV_BITS];

endmodule

// File: src/fcg_back.sv
// Back stages: data start, data sector count and free cluster count.
module fcg_back import fcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  fcg_item_t   in_item,
	output logic        done,
	output logic        too_small,
	output logic [6:0]  sectors_per_cluster,
	output logic [6:0]  reserved_sectors,
	output logic [19:0] fat_size_sectors,
	output logic [21:0] data_start_sector,
	output logic [26:0] free_clusters
);

	logic        vld_s1, vld_s2;
	logic        small_s1;
	logic [2:0]  sh_s1;
	logic [6:0]  rsvd_s1;
	logic [19:0] fat_s1;
	logic [21:0] dstart_s1;
	logic [32:0] diff_s1;

	logic        small_s2;
	logic [6:0]  spc_s2, rsvd_s2;
	logic [19:0] fat_s2;
	logic [21:0] dstart_s2;
	logic [26:0] free_s2;

	logic [6:0]  rsvd_c;
	logic [21:0] dstart_c;
	logic [32:0] diff_c;
	logic [31:0] shifted_c;

	always_comb begin
		rsvd_c    = fcg_rsvd(in_item.sh);
		dstart_c  = 22'(rsvd_c) + {1'b0, in_item.quot, 1'b0};
		diff_c    = {1'b0, in_item.total} - {11'b0, dstart_c};
		shifted_c = diff_s1[31:0] >> sh_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		small_s1  <= in_item.too_small;
		sh_s1     <= in_item.sh;
		rsvd_s1   <= rsvd_c;
		fat_s1    <= in_item.quot;
		dstart_s1 <= dstart_c;
		diff_s1   <= diff_c;

		small_s2 <= small_s1;
		if (small_s1) begin
			spc_s2    <= '0;
			rsvd_s2   <= '0;
			fat_s2    <= '0;
			dstart_s2 <= '0;
			free_s2   <= '0;
		end else begin
			spc_s2    <= 7'd1 << sh_s1;
			rsvd_s2   <= rsvd_s1;
			fat_s2    <= fat_s1;
			dstart_s2 <= dstart_s1;
			free_s2   <= diff_s1[32] ? '0 : shifted_c[26:0];
		end
	end

	assign done                = vld_s2;
	assign too_small           = small_s2;
	assign sectors_per_cluster = spc_s2;
	assign reserved_sectors    = rsvd_s2;
	assign fat_size_sectors    = fat_s2;
	assign data_start_sector   = dstart_s2;
	assign free_clusters       = free_s2;

endmodule
